// ===== rtl/core/sci_pkg.sv =====
// Package for the table soft clipper: curve ROM contents and shared widths.
// Used by sci_curve and soft_clip_interp; no dependencies of its own.
package sci_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned OutW    = 18;
  localparam int unsigned LevelW  = 17;
  localparam int unsigned FracW   = 12;
  localparam int unsigned IdxW    = 5;
  localparam int unsigned ProdW   = LevelW + FracW;

  // Last ROM entry; at or beyond this segment the magnitude saturates
  localparam logic [IdxW-1:0] RomLast = 5'd31;

  typedef logic [LevelW-1:0] level_t;
  typedef logic [IdxW-1:0]   rom_idx_t;

  // Monotonic curve, Q1.16 unsigned magnitude per segment
  function automatic level_t curve_rom(input rom_idx_t idx);
    level_t word;
    case (idx)
      5'd0:    word = 17'h00000;
      5'd1:    word = 17'h00FFD;
      5'd2:    word = 17'h01FEB;
      5'd3:    word = 17'h02FB9;
      5'd4:    word = 17'h03F5A;
      5'd5:    word = 17'h04EBF;
      5'd6:    word = 17'h05DDA;
      5'd7:    word = 17'h06CA0;
      5'd8:    word = 17'h07B04;
      5'd9:    word = 17'h088FE;
      5'd10:   word = 17'h09684;
      5'd11:   word = 17'h0A390;
      5'd12:   word = 17'h0B01C;
      5'd13:   word = 17'h0BC23;
      5'd14:   word = 17'h0C7A3;
      5'd15:   word = 17'h0D299;
      5'd16:   word = 17'h0DD06;
      5'd17:   word = 17'h0E6E9;
      5'd18:   word = 17'h0F045;
      5'd19:   word = 17'h0F91A;
      5'd20:   word = 17'h1016D;
      5'd21:   word = 17'h10941;
      5'd22:   word = 17'h11099;
      5'd23:   word = 17'h1177B;
      5'd24:   word = 17'h11DEA;
      5'd25:   word = 17'h123ED;
      5'd26:   word = 17'h12988;
      5'd27:   word = 17'h12EC1;
      5'd28:   word = 17'h1339C;
      5'd29:   word = 17'h1381F;
      5'd30:   word = 17'h13C4F;
      5'd31:   word = 17'h14030;
      default: word = 17'h00000;
    endcase
    return word;
  endfunction

endpackage

// ===== rtl/core/sci_curve.sv =====
// Magnitude-to-level mapping: ROM lookup of two adjacent segment ends and
// linear interpolation on the low magnitude bits. Depends on sci_pkg.
module sci_curve (
  input  logic [sci_pkg::SampleW-1:0] mag,
  output sci_pkg::level_t             level
);

  sci_pkg::rom_idx_t              idx;
  sci_pkg::rom_idx_t              idx_hi;
  logic                           sat;
  logic [sci_pkg::FracW-1:0]      frac;
  sci_pkg::level_t                lo;
  sci_pkg::level_t                hi;
  sci_pkg::level_t                diff;
  logic [sci_pkg::ProdW-1:0]      prod;
  sci_pkg::level_t                step;

  assign frac   = mag[sci_pkg::FracW-1:0];
  assign idx    = mag[sci_pkg::FracW +: sci_pkg::IdxW];
  // Any bit above the index field, or the last index itself, means saturate
  assign sat    = (|mag[sci_pkg::SampleW-1:sci_pkg::FracW+sci_pkg::IdxW])
                  || (idx == sci_pkg::RomLast);
  assign idx_hi = idx + sci_pkg::IdxW'(1);
  assign lo     = sci_pkg::curve_rom(idx);
  assign hi     = sci_pkg::curve_rom(idx_hi);
  assign diff   = hi - lo;
  assign prod   = {{sci_pkg::FracW{1'b0}}, diff} * {{sci_pkg::LevelW{1'b0}}, frac};
  assign step   = prod[sci_pkg::FracW +: sci_pkg::LevelW];

  always_comb begin
    if (sat) begin
      level = sci_pkg::curve_rom(sci_pkg::RomLast);
    end else begin
      level = lo + step;
    end
  end

endmodule

// ===== rtl/core/soft_clip_interp.sv =====
// Top level of the table soft clipper: input register, curve logic, result register.
// Depends on sci_pkg and sci_curve.
//
// Usage:
//   Input channel in_valid / in_ready / sample_in carries one signed Q15.16
//   sample per transaction. Output channel out_valid / out_ready / sample_out
//   carries the soft-clipped sample, signed Q1.16, 18 bits, one per input.
//   Path: a sample accepted into the input register is presented on sample_out
//   once it moves on into the result register, when the result register is free
//   (two register stages: input register, then result register, with the
//   ROM lookup and interpolation between them).
//   Throughput: one sample per cycle; both stages advance together whenever
//   the result register is empty or being emptied.
//   Stall: while out_ready is low and the result register is full, the input
//   register still takes one more sample; after that in_ready drops and both
//   stages hold their contents unchanged.
//   Reset: rst (synchronous, active high) empties both stages; no data is
//   kept across reset and there is no configuration.
module soft_clip_interp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [sci_pkg::SampleW-1:0] sample_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sci_pkg::OutW-1:0]    sample_out
);

  logic                        s1_valid;
  logic [sci_pkg::SampleW-1:0] s1_sample;
  logic                        s1_advance;
  logic                        s2_free;

  logic                        neg;
  logic [sci_pkg::SampleW-1:0] mag;
  sci_pkg::level_t             level;
  logic [sci_pkg::OutW-1:0]    level_ext;
  logic [sci_pkg::OutW-1:0]    result;

  assign s2_free    = !out_valid || out_ready;
  assign s1_advance = s1_valid && s2_free;
  assign in_ready   = !s1_valid || s2_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample <= sample_in;
    end
  end

  // Magnitude of the most negative sample wraps to 2^31, which saturates
  assign neg = s1_sample[sci_pkg::SampleW-1];
  assign mag = neg ? (~s1_sample + sci_pkg::SampleW'(1)) : s1_sample;

  sci_curve u_curve (
    .mag   (mag),
    .level (level)
  );

  assign level_ext = {1'b0, level};
  assign result    = neg ? (~level_ext + sci_pkg::OutW'(1)) : level_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      sample_out <= result;
    end
  end

endmodule
